@@ sv/jts_pkg.sv @@
// jts_pkg: item types, result codes, character constants and helpers for the
// json token splitter. No dependencies; every other file uses this package.

package jts_pkg;

	// result kind codes
	localparam logic [1:0] KIND_CONT  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// characters of interest
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_LBRACKET  = 8'h5B;
	localparam logic [7:0] CH_RBRACKET  = 8'h5D;
	localparam logic [7:0] CH_COLON     = 8'h3A;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_LF        = 8'h0A;
	localparam logic [7:0] CH_DQUOTE    = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_HASH      = 8'h23;

	// most results one input item can cause
	localparam int unsigned MAX_RES = 3;

	// input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       run_last;
	} out_item_t;

	// one result inside a bundle
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
	} res_t;

	// all results of one input item, entries 0 .. cnt-1 are used
	typedef struct packed {
		res_t [MAX_RES-1:0] ent;
		logic [1:0]         cnt;
	} bundle_t;

	// single-byte structural tokens
	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LBRACKET) ||
			(c == CH_RBRACKET) || (c == CH_COLON) || (c == CH_COMMA);
	endfunction

endpackage

@@ sv/jts_text_if.sv @@
// jts_text_if: valid/ready channel carrying text input items.
// Depends on jts_pkg for the payload type.

interface jts_text_if;
	logic              valid;
	logic              ready;
	jts_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/jts_token_if.sv @@
// jts_token_if: valid/ready channel carrying token result items.
// Depends on jts_pkg for the payload type.

interface jts_token_if;
	logic               valid;
	logic               ready;
	jts_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/jts_front.sv @@
// jts_front: accepts text items, runs the lexer state and builds one bundle
// of results per item. Depends on jts_pkg and jts_text_if.

module jts_front (
	input  logic              clk,
	input  logic              arst_n,
	jts_text_if.sink          text,
	input  logic              q_ready,
	output logic              push,
	output jts_pkg::bundle_t  bundle
);

	logic       string_q;
	logic [7:0] prior_q;
	logic       comment_q;
	logic       slash_q;
	logic       tok_q;

	logic       string_d;
	logic [7:0] prior_d;
	logic       comment_d;
	logic       slash_d;
	logic       tok_d;
	logic [1:0] n_d;
	jts_pkg::res_t [jts_pkg::MAX_RES-1:0] ent_d;

	logic accept;

	assign text.ready = q_ready;
	assign accept     = text.valid && text.ready;

	// lexer step for the incoming byte
	always_comb begin
		logic [7:0] c;
		c         = text.data.in_byte;
		string_d  = string_q;
		prior_d   = prior_q;
		comment_d = comment_q;
		slash_d   = slash_q;
		tok_d     = tok_q;
		n_d       = 2'd0;
		ent_d     = '0;

		if (comment_d) begin
			// inside a comment everything is dropped
			if (prior_d == jts_pkg::CH_STAR && c == jts_pkg::CH_SLASH) begin
				comment_d = 1'b0;
			end
			prior_d = c;
		end else if (c == jts_pkg::CH_SPACE || c == jts_pkg::CH_LF) begin
			// blank releases a held slash and is dropped
			if (slash_d) begin
				slash_d             = 1'b0;
				ent_d[n_d].kind     = tok_d ? jts_pkg::KIND_CONT : jts_pkg::KIND_START;
				ent_d[n_d].out_byte = jts_pkg::CH_SLASH;
				n_d                 = n_d + 2'd1;
				tok_d               = 1'b1;
			end
		end else if (slash_d && c == jts_pkg::CH_STAR) begin
			// slash then star opens a comment
			slash_d   = 1'b0;
			comment_d = 1'b1;
			prior_d   = jts_pkg::CH_SLASH;
		end else begin
			if (slash_d) begin
				slash_d             = 1'b0;
				ent_d[n_d].kind     = tok_d ? jts_pkg::KIND_CONT : jts_pkg::KIND_START;
				ent_d[n_d].out_byte = jts_pkg::CH_SLASH;
				n_d                 = n_d + 2'd1;
				tok_d               = 1'b1;
			end
			if (c == jts_pkg::CH_DQUOTE && prior_d != jts_pkg::CH_BACKSLASH) begin
				string_d = !string_d;
			end
			if (!string_d && c == jts_pkg::CH_SLASH) begin
				slash_d = 1'b1;
			end else if (!string_d && jts_pkg::is_sep(c)) begin
				ent_d[n_d].kind     = jts_pkg::KIND_START;
				ent_d[n_d].out_byte = c;
				n_d                 = n_d + 2'd1;
				tok_d               = 1'b0;
			end else begin
				ent_d[n_d].kind     = tok_d ? jts_pkg::KIND_CONT : jts_pkg::KIND_START;
				ent_d[n_d].out_byte = c;
				n_d                 = n_d + 2'd1;
				tok_d               = 1'b1;
			end
			prior_d = c;
		end

		// end of stream: flush slash, add end marker, back to reset state
		if (text.data.final_byte) begin
			if (slash_d) begin
				ent_d[n_d].kind     = tok_d ? jts_pkg::KIND_CONT : jts_pkg::KIND_START;
				ent_d[n_d].out_byte = jts_pkg::CH_SLASH;
				n_d                 = n_d + 2'd1;
			end
			ent_d[n_d].kind     = jts_pkg::KIND_END;
			ent_d[n_d].out_byte = 8'd0;
			n_d                 = n_d + 2'd1;
			string_d  = 1'b0;
			prior_d   = jts_pkg::CH_HASH;
			comment_d = 1'b0;
			slash_d   = 1'b0;
			tok_d     = 1'b0;
		end
	end

	// items with no result are not queued
	assign push       = accept && (n_d != 2'd0);
	assign bundle.ent = ent_d;
	assign bundle.cnt = n_d;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_q  <= 1'b0;
			prior_q   <= jts_pkg::CH_HASH;
			comment_q <= 1'b0;
			slash_q   <= 1'b0;
			tok_q     <= 1'b0;
		end else if (accept) begin
			string_q  <= string_d;
			prior_q   <= prior_d;
			comment_q <= comment_d;
			slash_q   <= slash_d;
			tok_q     <= tok_d;
		end
	end

endmodule

@@ sv/jts_queue.sv @@
// jts_queue: small first-in first-out queue of result bundles between the
// front and the back. Depends on jts_pkg.

module jts_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jts_pkg::bundle_t wr_data,
	output logic             not_full,
	input  logic             pop,
	output logic             not_empty,
	output jts_pkg::bundle_t rd_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	jts_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign not_full  = count_q != CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign rd_data   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/jts_back.sv @@
// jts_back: takes queued bundles and sends their results one item per cycle
// while ready, marking the last of each. Depends on jts_pkg and jts_token_if.

module jts_back (
	input  logic             clk,
	input  logic             arst_n,
	jts_token_if.source      token,
	input  logic             q_valid,
	input  jts_pkg::bundle_t q_data,
	output logic             q_pop
);

	jts_pkg::bundle_t cur_q;
	logic             cur_valid_q;
	logic [1:0]       idx_q;

	logic fire;
	logic last_here;
	logic take;

	assign fire      = cur_valid_q && token.ready;
	assign last_here = idx_q == (cur_q.cnt - 2'd1);
	assign take      = !cur_valid_q || (fire && last_here);
	assign q_pop     = take && q_valid;

	// output from the current bundle
	assign token.valid         = cur_valid_q;
	assign token.data.kind     = cur_q.ent[idx_q].kind;
	assign token.data.out_byte = cur_q.ent[idx_q].out_byte;
	assign token.data.run_last = last_here;

	// bundle payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	// sequencing over the bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (take) begin
			cur_valid_q <= q_valid;
			idx_q       <= 2'd0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// end marker is always the last result of its item
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		token.valid && token.data.kind == jts_pkg::KIND_END |-> token.data.run_last)
		else $error("end marker without run_last");

	// index stays inside the loaded bundle
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_q.cnt != 2'd0) && (idx_q < cur_q.cnt))
		else $error("result index beyond bundle");

	// more results of the same item follow directly
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		token.valid && token.ready && !token.data.run_last |=> token.valid)
		else $error("item results broken off");

endmodule

@@ sv/json_token_splitter_core.sv @@
// json_token_splitter_core: top level of the json token splitter.
// Depends on jts_pkg, jts_text_if, jts_token_if, jts_front, jts_queue, jts_back.
//
// Usage:
//   text  (sink)   one item per byte of JSON text: in_byte and final_byte.
//   token (source) one item per kept byte: kind (continue, start, end),
//                  out_byte, and run_last on the last result of an input item.
// Blanks and comments are dropped, so an input item gives zero to three
// results; a final_byte item always ends with an end marker.
// The first result of an item is offered once the item has been written to
// the queue and its bundle loaded into the output stage of the back end.
// Throughput: one text item per cycle while each item causes at most one
// result and the receiver is ready; the back end sends one result per cycle
// while token.ready is high, so items with two or three results can fill the queue.
// A queue of QUEUE_DEPTH result bundles sits between the lexer front end and
// the output sequencer; text.ready depends only on the queue fill, so a
// stalled receiver blocks the input only once the queue is full.
// Reset empties the queue and returns the lexer to its start-of-stream
// state; after a final_byte item the lexer returns to that state by itself.

module json_token_splitter_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	jts_text_if.sink    text,
	jts_token_if.source token
);

	logic             push;
	logic             not_full;
	logic             pop;
	logic             not_empty;
	jts_pkg::bundle_t wr_bundle;
	jts_pkg::bundle_t rd_bundle;

	jts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.q_ready(not_full),
		.push   (push),
		.bundle (wr_bundle)
	);

	jts_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (wr_bundle),
		.not_full (not_full),
		.pop      (pop),
		.not_empty(not_empty),
		.rd_data  (rd_bundle)
	);

	jts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.token  (token),
		.q_valid(not_empty),
		.q_data (rd_bundle),
		.q_pop  (pop)
	);

endmodule

@@ dv/tb.sv @@
// tb: self-checking testbench for json_token_splitter_core, driving text bytes
// and predicting every token item. Depends on jts_pkg, jts_text_if, jts_token_if.
`timescale 1ns / 100ps

module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// text source and token sink drive through these
	logic              src_valid = 1'b0;
	jts_pkg::in_item_t src_data = '0;
	logic              sink_ready = 1'b0;

	jts_text_if  text_bus ();
	jts_token_if token_bus ();

	assign text_bus.valid = src_valid;
	assign text_bus.data = src_data;
	assign token_bus.ready = sink_ready;

	json_token_splitter_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.text  (text_bus),
		.token (token_bus)
	);

	always #1 clk = ~clk;

	// lexer shadow state
	logic       lex_in_string;
	logic [7:0] lex_prior;
	logic       lex_in_comment;
	logic       lex_slash_held;
	logic       lex_token_open;

	jts_pkg::out_item_t exp_tokens[$];
	jts_pkg::out_item_t step_res[$];
	int        err_count = 0;
	int        text_sent = 0;
	bit        src_idle = 1'b1;
	bit        sink_idle = 1'b1;
	int        sink_wait = 0;

	task automatic report(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		err_count++;
	endtask

	// back to start-of-stream state
	function automatic void lex_clear();
		lex_in_string = 1'b0;
		lex_prior = jts_pkg::CH_HASH;
		lex_in_comment = 1'b0;
		lex_slash_held = 1'b0;
		lex_token_open = 1'b0;
	endfunction

	function automatic void emit(input logic [1:0] k, input logic [7:0] b);
		jts_pkg::out_item_t r;
		r.kind = k;
		r.out_byte = b;
		r.run_last = 1'b0;
		step_res = {step_res, r};
	endfunction

	function automatic void emit_text(input logic [7:0] b);
		emit(lex_token_open ? jts_pkg::KIND_CONT : jts_pkg::KIND_START, b);
		lex_token_open = 1'b1;
	endfunction

	function automatic void free_slash();
		if (lex_slash_held) begin
			lex_slash_held = 1'b0;
			emit_text(jts_pkg::CH_SLASH);
		end
	endfunction

	// one byte through the lexer
	function automatic void lex_byte(input logic [7:0] c);
		logic structural;
		structural = 1'b0;
		if (lex_in_comment) begin
			if (lex_prior == jts_pkg::CH_STAR && c == jts_pkg::CH_SLASH)
				lex_in_comment = 1'b0;
			lex_prior = c;
			return;
		end
		if (c == jts_pkg::CH_SPACE || c == jts_pkg::CH_LF) begin
			free_slash();
			return;
		end
		if (lex_slash_held) begin
			if (c == jts_pkg::CH_STAR) begin
				lex_slash_held = 1'b0;
				lex_in_comment = 1'b1;
				lex_prior = jts_pkg::CH_SLASH;
				return;
			end
			free_slash();
		end
		if (c == jts_pkg::CH_DQUOTE && lex_prior != jts_pkg::CH_BACKSLASH)
			lex_in_string = ~lex_in_string;
		case (c)
			jts_pkg::CH_LBRACE, jts_pkg::CH_RBRACE, jts_pkg::CH_LBRACKET,
			jts_pkg::CH_RBRACKET, jts_pkg::CH_COLON, jts_pkg::CH_COMMA:
				structural = 1'b1;
			default: structural = 1'b0;
		endcase
		if (!lex_in_string && c == jts_pkg::CH_SLASH) begin
			lex_slash_held = 1'b1;
		end else if (!lex_in_string && structural) begin
			emit(jts_pkg::KIND_START, c);
			lex_token_open = 1'b0;
		end else begin
			emit_text(c);
		end
		lex_prior = c;
	endfunction

	// expected token items of one accepted text item
	function automatic void predict_tokens(input jts_pkg::in_item_t it);
		jts_pkg::out_item_t r;
		step_res.delete();
		lex_byte(it.in_byte);
		if (it.final_byte) begin
			free_slash();
			emit(jts_pkg::KIND_END, 8'h00);
			lex_clear();
		end
		foreach (step_res[i]) begin
			r = step_res[i];
			r.run_last = (i == step_res.size() - 1);
			exp_tokens = {exp_tokens, r};
		end
	endfunction

	// send one text item, with a random gap first while the source idles
	task automatic send_text(input logic [7:0] b, input logic fin);
		int gap;
		jts_pkg::in_item_t it;
		gap = src_idle ? $urandom_range(0, 7) : 0;
		it.in_byte = b;
		it.final_byte = fin;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= it;
		do @(posedge clk); while (!text_bus.ready);
		predict_tokens(it);
		text_sent++;
	endtask

	task automatic send_str(input string s, input logic fin);
		for (int i = 0; i < s.len(); i++)
			send_text(s[i], fin && (i == s.len() - 1));
	endtask

	// token sink with random stalls while the sink idles
	always @(posedge clk) begin
		if (token_bus.valid && token_bus.ready)
			sink_wait = sink_idle ? $urandom_range(0, 7) : 0;
		if (sink_wait > 0) begin
			sink_ready <= 1'b0;
			sink_wait--;
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// compare each token item with the oldest expectation
	always @(posedge clk) begin
		jts_pkg::out_item_t want;
		jts_pkg::out_item_t got;
		if (arst_n && token_bus.valid && token_bus.ready) begin
			got = token_bus.data;
			if (exp_tokens.size() == 0) begin
				report($sformatf("unexpected token item kind %0d byte %02h",
					got.kind, got.out_byte));
			end else begin
				want = exp_tokens.pop_front();
				if (got.kind != want.kind)
					report($sformatf("kind got %0d want %0d (byte %02h)",
						got.kind, want.kind, want.out_byte));
				if (got.out_byte != want.out_byte)
					report($sformatf("out_byte got %02h want %02h",
						got.out_byte, want.out_byte));
				if (got.run_last != want.run_last)
					report($sformatf("run_last got %0d want %0d (byte %02h)",
						got.run_last, want.run_last, want.out_byte));
			end
		end
	end

	// byte extremes, separators and blanks
	task automatic test_extremes();
		send_text(8'h00, 1'b0);
		send_text(8'hFF, 1'b0);
		send_str(", {\n", 1'b0);
	endtask

	// escaped quote, slash, blank and colon inside a string
	task automatic test_strings();
		send_str("\"\\\"/ :\"", 1'b0);
	endtask

	// slash released by a byte and by a blank, comment with slash-star-slash
	task automatic test_comments();
		send_str("/x/ /*/a*/", 1'b0);
	endtask

	// stream ends: held slash plus byte, lone slash, blank, open comment
	task automatic test_final();
		send_str("/q", 1'b1);
		send_str("/", 1'b1);
		send_str(" ", 1'b1);
		send_str("/*", 1'b1);
	endtask

	// mostly JSON-like bytes, some fully random
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 15))
			0: begin
				case ($urandom_range(0, 5))
					0: return jts_pkg::CH_LBRACE;
					1: return jts_pkg::CH_RBRACE;
					2: return jts_pkg::CH_LBRACKET;
					3: return jts_pkg::CH_RBRACKET;
					4: return jts_pkg::CH_COLON;
					default: return jts_pkg::CH_COMMA;
				endcase
			end
			1: return jts_pkg::CH_DQUOTE;
			2: return jts_pkg::CH_BACKSLASH;
			3: return jts_pkg::CH_SLASH;
			4: return jts_pkg::CH_STAR;
			5: return jts_pkg::CH_SPACE;
			6: return jts_pkg::CH_LF;
			7: return 8'($urandom_range(0, 255));
			8, 9: return 8'($urandom_range(8'h30, 8'h39));
			default: return 8'($urandom_range(8'h61, 8'h7A));
		endcase
	endfunction

	task automatic send_rand(input logic [7:0] b);
		send_text(b, $urandom_range(0, 39) == 0);
	endtask

	// random fragments: plain bytes, comments and strings
	task automatic test_random();
		int base;
		int phase;
		int len;
		base = text_sent;
		while (text_sent < base + 400) begin
			// idling per phase: both, none, sink only, source only
			phase = ((text_sent - base) / 100) % 4;
			src_idle = (phase == 0) || (phase == 3);
			sink_idle = (phase == 0) || (phase == 2);
			len = $urandom_range(0, 5);
			case ($urandom_range(0, 11))
				10: begin
					send_rand(jts_pkg::CH_SLASH);
					send_rand(jts_pkg::CH_STAR);
					repeat (len) send_rand(pick_char());
					send_rand(jts_pkg::CH_STAR);
					send_rand(jts_pkg::CH_SLASH);
				end
				11: begin
					send_rand(jts_pkg::CH_DQUOTE);
					repeat (len) send_rand(pick_char());
					send_rand(jts_pkg::CH_DQUOTE);
				end
				default: send_rand(pick_char());
			endcase
		end
		src_valid <= 1'b0;
	endtask

	initial begin
		lex_clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_strings();
		test_comments();
		test_final();
		test_random();
		while (exp_tokens.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// run limit
	initial begin
		#1000000;
		$display("FAIL");
		$finish;
	end

endmodule
